### hdl/dtpa_pkg.sv
// Shared types and constants for the delayed threshold protection alarm.
`timescale 1ns / 1ps

package dtpa_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_DIR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd6;

    localparam logic [1:0] MODE_LATCHED = 2'd0;
    localparam logic [1:0] MODE_AUTO    = 2'd1;
    localparam logic [1:0] MODE_STALL   = 2'd2;

    localparam int TIMER_W = 32;

    typedef struct packed {
        logic               enable;
        logic [1:0]         alarm_mode;
        logic               trip_direction;
        logic [7:0]         hysteresis;
        logic signed [15:0] threshold;
        logic [15:0]        timeout;
        logic [15:0]        scale;
    } t_cfg;

endpackage

### hdl/dtpa_cfg.sv
// Configuration register file for the protection alarm.
`timescale 1ns / 1ps

module dtpa_cfg
    import dtpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.alarm_mode     <= MODE_LATCHED;
            r_cfg.trip_direction <= 1'b0;
            r_cfg.hysteresis     <= '0;
            r_cfg.threshold      <= '0;
            r_cfg.timeout        <= '0;
            r_cfg.scale          <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:     r_cfg.enable         <= i_cfg_wdata[0];
                REG_ALARM_MODE: r_cfg.alarm_mode     <= i_cfg_wdata[1:0];
                REG_TRIP_DIR:   r_cfg.trip_direction <= i_cfg_wdata[0];
                REG_HYSTERESIS: r_cfg.hysteresis     <= i_cfg_wdata[7:0];
                REG_THRESHOLD:  r_cfg.threshold      <= $signed(i_cfg_wdata[15:0]);
                REG_TIMEOUT:    r_cfg.timeout        <= i_cfg_wdata[15:0];
                REG_SCALE:      r_cfg.scale          <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/dtpa_core.sv
// Alarm state (trip timer, reference sample, flag) and its next-state logic.
`timescale 1ns / 1ps

module dtpa_core
    import dtpa_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_clear,
    input  t_cfg                    i_cfg,
    output logic                    o_alarm_next
);

    localparam int CW = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 2;
    localparam int MW = ((SAMPLE_WIDTH + 1) > 16) ? (SAMPLE_WIDTH + 1) : 16;

    logic [TIMER_W-1:0]      r_timer, n_timer;
    logic [SAMPLE_WIDTH-1:0] r_ref, n_ref;
    logic                    r_alarm, n_alarm;

    logic [TIMER_W-1:0]      limit;
    logic [TIMER_W-1:0]      timer_inc;
    logic signed [CW-1:0]    s_ext, thr_ext, hys_ext;
    logic signed [SAMPLE_WIDTH:0] diff;
    logic [SAMPLE_WIDTH:0]   diff_mag;
    logic [MW-1:0]           mag_ext, thr_u_ext;
    logic                    flag_in, beyond, release_hit;

    always_comb begin
        limit     = TIMER_W'(i_cfg.timeout) * TIMER_W'(i_cfg.scale);
        timer_inc = r_timer + TIMER_W'(1);

        s_ext   = $signed({{(CW - SAMPLE_WIDTH){i_sample[SAMPLE_WIDTH-1]}}, i_sample});
        thr_ext = $signed({{(CW - 16){i_cfg.threshold[15]}}, i_cfg.threshold});
        hys_ext = $signed({{(CW - 8){1'b0}}, i_cfg.hysteresis});

        diff      = $signed({i_sample[SAMPLE_WIDTH-1], i_sample})
                  - $signed({r_ref[SAMPLE_WIDTH-1], r_ref});
        diff_mag  = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH + 1)'(-diff)
                                       : (SAMPLE_WIDTH + 1)'(diff);
        mag_ext   = MW'(diff_mag);
        thr_u_ext = MW'($unsigned(i_cfg.threshold));

        beyond      = i_cfg.trip_direction ? (s_ext >= thr_ext) : (s_ext <= thr_ext);
        release_hit = i_cfg.trip_direction ? (s_ext <= thr_ext - hys_ext)
                                           : (s_ext >= thr_ext + hys_ext);

        flag_in = r_alarm & ~i_clear;
        n_timer = r_timer;
        n_ref   = r_ref;
        n_alarm = flag_in;

        if (!i_cfg.enable) begin
            if (i_cfg.alarm_mode == MODE_AUTO || i_cfg.alarm_mode == MODE_STALL) begin
                n_alarm = 1'b0;
            end
            n_timer = '0;
            n_ref   = i_sample;
        end else if (i_cfg.alarm_mode == MODE_STALL) begin
            if (mag_ext >= thr_u_ext) begin
                n_timer = '0;
                n_ref   = i_sample;
            end else if (r_timer < limit) begin
                n_timer = timer_inc;
            end else begin
                n_alarm = 1'b1;
            end
        end else if (!flag_in) begin
            if (!beyond) begin
                if (r_timer != '0) begin
                    n_timer = r_timer - TIMER_W'(1);
                end
            end else if (timer_inc >= limit) begin
                n_alarm = 1'b1;
                n_timer = '0;
            end else begin
                n_timer = timer_inc;
            end
        end else if (i_cfg.alarm_mode == MODE_AUTO) begin
            if (release_hit) begin
                n_alarm = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_ref   <= '0;
            r_alarm <= 1'b0;
        end else if (i_fire) begin
            r_timer <= n_timer;
            r_ref   <= n_ref;
            r_alarm <= n_alarm;
        end
    end

    assign o_alarm_next = n_alarm;

    // state only moves on a processed beat
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_alarm) && $stable(r_timer) && $stable(r_ref))
        else $error("alarm state changed without a beat");

    a_disabled_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_cfg.enable |=> r_timer == '0 && r_ref == $past(i_sample))
        else $error("disabled beat did not reset timer and reference");

    a_trip_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_alarm) && $past(i_cfg.alarm_mode) != MODE_STALL |-> r_timer == '0)
        else $error("threshold trip left timer running");

endmodule

### hdl/delayed_threshold_protection_alarm_top.sv
// An accepted input beat waits in the input register (r_sample, r_clear); once the
// output register is free, its result is registered into r_alarm_out with o_out_valid.
// Throughput: one beat per cycle unless the output stalls.
// A result waiting on a stalled output still lets one further input beat in.
// Reset (i_rst_n low, synchronous) clears handshake state, alarm state and
// configuration; scale resets to 1, everything else to 0.
`timescale 1ns / 1ps

module delayed_threshold_protection_alarm_top
    import dtpa_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_external_clear,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_alarm
);

    t_cfg                    cfg;
    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_clear;
    logic                    r_out_valid;
    logic                    r_alarm_out;
    logic                    fire;
    logic                    alarm_next;

    dtpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dtpa_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_sample     (r_sample),
        .i_clear      (r_clear),
        .i_cfg        (cfg),
        .o_alarm_next (alarm_next)
    );

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_sample <= i_sample;
            r_clear  <= i_external_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_alarm_out <= alarm_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_alarm     = r_alarm_out;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid && r_alarm_out == $past(alarm_next))
        else $error("processed beat did not reach the output register");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free stage");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_sample) && $stable(r_clear))
        else $error("pending input beat lost");

endmodule

### tb/dtpa_alarm_check.sv
// Alarm predictor and result comparator for the protection alarm testbench.
`timescale 1ns / 1ps

module dtpa_alarm_check
    import dtpa_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_external_clear,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic                    i_alarm,
    output int                      o_fail_count,
    output int                      o_pending
);

    t_cfg                    settings;
    logic [TIMER_W-1:0]      trip_count;
    logic [SAMPLE_WIDTH-1:0] ref_level;
    logic                    alarm_state;
    logic                    expected_alarms[$];
    logic                    want;
    int                      fails = 0;

    function automatic logic step_alarm(input logic [SAMPLE_WIDTH-1:0] smp, input logic clr);
        longint             s;
        longint             thr;
        longint             hyst;
        longint             mag;
        logic [TIMER_W-1:0] limit;
        logic               beyond;
        logic               release_now;
        s     = longint'($signed(smp));
        thr   = longint'($signed(settings.threshold));
        hyst  = longint'({56'd0, settings.hysteresis});
        limit = TIMER_W'(settings.timeout) * TIMER_W'(settings.scale);

        if (clr)
            alarm_state = 1'b0;

        if (!settings.enable) begin
            if (settings.alarm_mode == MODE_AUTO || settings.alarm_mode == MODE_STALL)
                alarm_state = 1'b0;
            trip_count = '0;
            ref_level  = smp;
        end else if (settings.alarm_mode == MODE_STALL) begin
            mag = s - longint'($signed(ref_level));
            if (mag < 0)
                mag = -mag;
            // threshold is an unsigned minimum step here
            if (mag >= longint'({48'd0, settings.threshold})) begin
                trip_count = '0;
                ref_level  = smp;
            end else if (trip_count < limit) begin
                trip_count = trip_count + 1'b1;
            end else begin
                alarm_state = 1'b1;
            end
        end else if (!alarm_state) begin
            beyond = settings.trip_direction ? (s >= thr) : (s <= thr);
            if (!beyond) begin
                if (trip_count != 0)
                    trip_count = trip_count - 1'b1;
            end else begin
                trip_count = trip_count + 1'b1;
                if (trip_count >= limit) begin
                    alarm_state = 1'b1;
                    trip_count  = '0;
                end
            end
        end else if (settings.alarm_mode == MODE_AUTO) begin
            release_now = settings.trip_direction ? (s <= thr - hyst) : (s >= thr + hyst);
            if (release_now)
                alarm_state = 1'b0;
        end
        return alarm_state;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings       = '0;
            settings.scale = 16'd1;
            trip_count     = '0;
            ref_level      = '0;
            alarm_state    = 1'b0;
            expected_alarms.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENABLE:     settings.enable         = i_cfg_wdata[0];
                    REG_ALARM_MODE: settings.alarm_mode     = i_cfg_wdata[1:0];
                    REG_TRIP_DIR:   settings.trip_direction = i_cfg_wdata[0];
                    REG_HYSTERESIS: settings.hysteresis     = i_cfg_wdata[7:0];
                    REG_THRESHOLD:  settings.threshold      = i_cfg_wdata[15:0];
                    REG_TIMEOUT:    settings.timeout        = i_cfg_wdata[15:0];
                    REG_SCALE:      settings.scale          = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end

            // result side first, so a beat arriving this edge is never popped early
            if (i_out_valid && !i_out_stall) begin
                if (expected_alarms.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: alarm beat %0b at %0t with nothing expected",
                                 i_alarm, $realtime);
                end else begin
                    want = expected_alarms.pop_front();
                    if (i_alarm !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: alarm mismatch at %0t: expected %0b, got %0b",
                                     $realtime, want, i_alarm);
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                expected_alarms.push_back(step_alarm(i_sample, i_external_clear));
        end
        o_fail_count <= fails;
        o_pending    <= expected_alarms.size();
    end

endmodule

### tb/delayed_threshold_protection_alarm_top_tb.sv
// Testbench top: sample and configuration stimulus for the protection alarm, and the verdict.
`timescale 1ns / 1ps

module delayed_threshold_protection_alarm_top_tb
    import dtpa_pkg::*;
;

    localparam int         SAMPLE_W        = 16;
    localparam int         SETTLE_CYCLES   = 6;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         PHASES          = 24;
    localparam int         BEATS_PER_PHASE = 45;
    localparam logic [1:0] MODE_SPARE      = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample    = '0;
    logic                  ext_clear = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  alarm;
    int                    fail_count;
    int                    pending;
    int                    cycles    = 0;
    int                    send_idle_pct = 19;
    int                    recv_idle_pct = 59;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    delayed_threshold_protection_alarm_top #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_sample        (sample),
        .i_external_clear(ext_clear),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_alarm         (alarm)
    );

    dtpa_alarm_check #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) alarm_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_sample        (sample),
        .i_external_clear(ext_clear),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_alarm         (alarm),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= smp;
        ext_clear <= clr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input t_cfg s);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_ENABLE;
        cfg_wdata <= CFG_DATA_W'(s.enable);
        @(posedge clk);
        cfg_idx   <= REG_ALARM_MODE;
        cfg_wdata <= CFG_DATA_W'(s.alarm_mode);
        @(posedge clk);
        cfg_idx   <= REG_TRIP_DIR;
        cfg_wdata <= CFG_DATA_W'(s.trip_direction);
        @(posedge clk);
        cfg_idx   <= REG_HYSTERESIS;
        cfg_wdata <= CFG_DATA_W'(s.hysteresis);
        @(posedge clk);
        cfg_idx   <= REG_THRESHOLD;
        cfg_wdata <= s.threshold;
        @(posedge clk);
        cfg_idx   <= REG_TIMEOUT;
        cfg_wdata <= s.timeout;
        @(posedge clk);
        cfg_idx   <= REG_SCALE;
        cfg_wdata <= s.scale;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_cfg pick_settings(input int p);
        t_cfg s;
        s.enable = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2: s.alarm_mode = MODE_LATCHED;
            3, 4, 5: s.alarm_mode = MODE_AUTO;
            6, 7, 8: s.alarm_mode = MODE_STALL;
            default: s.alarm_mode = MODE_SPARE;
        endcase
        s.trip_direction = 1'($urandom_range(0, 1));
        s.hysteresis = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 12));
        if (s.alarm_mode == MODE_STALL && $urandom_range(0, 7) != 0)
            s.threshold = 16'($urandom_range(0, 40));
        else
            s.threshold = 16'($urandom);
        s.timeout = 16'($urandom_range(0, 6));
        s.scale   = 16'($urandom_range(0, 4));
        if ($urandom_range(0, 11) == 0) begin
            s.timeout = 16'hffff;
            s.scale   = $urandom_range(0, 1) ? 16'hffff : 16'd1;
        end
        if (p == 0) begin
            s.enable         = 1'b1;
            s.alarm_mode     = MODE_AUTO;
            s.trip_direction = 1'b1;
            s.hysteresis     = 8'hff;
            s.threshold      = 16'sh7fff;
            s.timeout        = 16'hffff;
            s.scale          = 16'hffff;
        end else if (p == 1) begin
            s.enable         = 1'b1;
            s.alarm_mode     = MODE_LATCHED;
            s.trip_direction = 1'b0;
            s.hysteresis     = 8'h00;
            s.threshold      = 16'sh8000;
            s.timeout        = 16'h0000;
            s.scale          = 16'h0000;
        end
        return s;
    endfunction

    initial begin
        t_cfg                s;
        int                  level;
        int                  jitter;
        int                  offset;
        int                  value;
        logic                trend;

        level = 0;
        trend = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset, range extremes
        send_beat(16'h8000, 1'b1);
        send_beat(16'h7fff, 1'b0);
        drain();

        // latched, zero limit trips on the first beat beyond
        s                = '0;
        s.enable         = 1'b1;
        s.alarm_mode     = MODE_LATCHED;
        s.scale          = 16'd1;
        apply_settings(s);
        send_beat(16'd100, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7fff, 1'b0);
        send_beat(16'd5, 1'b1);
        drain();

        // auto-reset upward at the top of the range, widest release margin
        s.alarm_mode     = MODE_AUTO;
        s.trip_direction = 1'b1;
        s.threshold      = 16'sh7fff;
        s.hysteresis     = 8'hff;
        s.timeout        = 16'd2;
        apply_settings(s);
        send_beat(16'h7fff, 1'b0);
        send_beat(16'h7fff, 1'b0);
        send_beat(16'h7f01, 1'b0);
        send_beat(16'h7f00, 1'b0);
        drain();

        // downward at the bottom of the range, released at the bound 16'h80ff
        s.trip_direction = 1'b0;
        s.threshold      = 16'sh8000;
        s.timeout        = 16'd1;
        apply_settings(s);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h80ff, 1'b0);
        drain();

        // stall with zero step: every beat counts as movement
        s.alarm_mode     = MODE_STALL;
        s.threshold      = 16'sh0000;
        s.timeout        = 16'd0;
        apply_settings(s);
        send_beat(16'h1234, 1'b0);
        send_beat(16'h1234, 1'b0);
        drain();

        // stall with the step read as 65535
        s.threshold      = 16'shffff;
        s.timeout        = 16'd1;
        apply_settings(s);
        send_beat(16'h1234, 1'b0);
        send_beat(16'h1234, 1'b0);
        send_beat(16'h8000, 1'b0);
        drain();

        // spare mode behaves as latched, and holds the alarm while disabled
        s.alarm_mode     = MODE_SPARE;
        s.threshold      = 16'sh0000;
        s.timeout        = 16'd0;
        apply_settings(s);
        send_beat(16'hffff, 1'b1);
        drain();
        s.enable         = 1'b0;
        apply_settings(s);
        send_beat(16'h0001, 1'b0);
        drain();

        // limit lowered below a running timer
        s.enable         = 1'b1;
        s.alarm_mode     = MODE_LATCHED;
        s.timeout        = 16'd4;
        apply_settings(s);
        send_beat(16'hffff, 1'b1);
        send_beat(16'hfff0, 1'b0);
        drain();
        s.timeout        = 16'd1;
        apply_settings(s);
        send_beat(16'hffff, 1'b0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES / 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 19;
            end else if (p == 2 * PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            s = pick_settings(p);
            apply_settings(s);
            jitter = int'({16'd0, s.threshold}) / 2 + 1;
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) == 0)
                    trend = ~trend;
                if ($urandom_range(0, 9) == 0) begin
                    value = $urandom_range(0, 65535);
                end else if (s.alarm_mode == MODE_STALL) begin
                    if ($urandom_range(0, 14) == 0)
                        level = int'($urandom_range(0, 65535)) - 32768;
                    value = level + int'($urandom_range(0, 2 * jitter)) - jitter;
                end else begin
                    offset = $urandom_range(0, int'(s.hysteresis) + 6);
                    value  = int'(s.threshold) + (trend ? offset : -offset);
                end
                send_beat(SAMPLE_W'(value), ($urandom_range(0, 19) == 0));
            end
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### delayed_threshold_protection_alarm_top.f
hdl/dtpa_pkg.sv
hdl/dtpa_cfg.sv
hdl/dtpa_core.sv
hdl/delayed_threshold_protection_alarm_top.sv
tb/dtpa_alarm_check.sv
tb/delayed_threshold_protection_alarm_top_tb.sv
